// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while the block is out of reset.
`define ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== hdl/txc_pkg.sv =====
package txc_pkg;

  // Action codes carried in the input word.
  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Special character codes and blank cell contents.
  localparam logic [7:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [7:0] CODE_BACKSPACE = 8'h08;
  localparam logic [7:0] CODE_SPACE     = 8'h20;
  localparam logic [7:0] RESET_ATTR     = 8'h07;

  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_word_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attribute;
    logic [6:0] cursor_col;
    logic [4:0] cursor_line;
    logic       scrolled;
  } out_word_t;

endpackage

// ===== hdl/text_console_writer.sv =====
// Channel  | Ports                          | Direction | Word
// input    | in_valid, in_ready, in_data    | in        | txc_pkg::in_word_t
// result   | out_valid, out_ready, out_data | out       | txc_pkg::out_word_t
// config   | cfg_we, cfg_wdata              | in        | text attribute byte
//
// A put is written from the idle state; a read goes on to ST_READ for the cell RAM read port.
// A put that scrolls blanks the new bottom row cell by cell in ST_BLANK.
// After reset a clearing pass writes all ROWS*COLUMNS cells before the first
// word is accepted; configuration is taken meanwhile.
// One word is worked on at a time; a finished result parks in a holding
// register while out_ready is low, and the next word waits until it leaves.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  txc_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output txc_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int CIW   = $clog2(COLUMNS);
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [CW-1:0]  COLS_C    = CW'(COLUMNS);
  localparam logic [CIW-1:0] LAST_COL  = CIW'(COLUMNS - 1);
  localparam logic [RW-1:0]  LAST_ROW  = RW'(ROWS - 1);
  localparam logic [AW-1:0]  LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0]  COLS_A    = AW'(COLUMNS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_BLANK = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // Screen rows live in the RAM as a ring; top_r is the physical row shown first.
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
                                             input logic [RW-1:0] top);
    logic [RW:0] s;
    s = {1'b0, r} + {1'b0, top};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                              input logic [CIW-1:0] c);
    return AW'(prow) * COLS_A + AW'(c);
  endfunction

  logic [2:0]               st_r, st_nxt;
  logic [CW-1:0]            col_r, col_nxt;
  logic [RW-1:0]            row_r, row_nxt;
  logic [RW-1:0]            top_r, top_nxt;
  logic [7:0]               attr_r;
  logic [AW-1:0]            clr_r, clr_nxt;
  logic [RW-1:0]            bl_row_r, bl_row_nxt;
  logic [CIW-1:0]           bl_cnt_r, bl_cnt_nxt;
  logic                     bl_put_r, bl_put_nxt;
  logic [7:0]               bl_char_r, bl_char_nxt;
  logic                     rd_ok_r, rd_ok_nxt;
  txc_pkg::out_word_t       res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  txc_pkg::out_word_t       out_data_r, out_data_nxt;
  logic [15:0]              rdata_r;

  logic [15:0]              mem [CELLS];
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [15:0]              mem_wdata;
  logic [AW-1:0]            mem_raddr;

  logic                     in_fire;
  logic                     out_free;
  logic                     fin;
  txc_pkg::out_word_t       fin_res;
  logic                     rd_in_range;

  assign in_ready  = (st_r == ST_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rd_in_range = (32'(in_data.read_row) < ROWS) && (32'(in_data.read_col) < COLUMNS);

  // Cell RAM: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // Next-state logic for clearing, puts, reads and scroll blanking.
  always_comb begin
    st_nxt        = st_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    top_nxt       = top_r;
    clr_nxt       = clr_r;
    bl_row_nxt    = bl_row_r;
    bl_cnt_nxt    = bl_cnt_r;
    bl_put_nxt    = bl_put_r;
    bl_char_nxt   = bl_char_r;
    rd_ok_nxt     = rd_ok_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = {attr_r, txc_pkg::CODE_SPACE};
    mem_raddr     = '0;
    fin           = 1'b0;
    fin_res       = '0;

    case (st_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = {txc_pkg::RESET_ATTR, txc_pkg::CODE_SPACE};
        if (clr_r == LAST_CELL) begin
          st_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.action == txc_pkg::ACT_READ) begin
            if (rd_in_range) begin
              mem_raddr = cell_addr(phys_row(RW'(in_data.read_row), top_r),
                                    CIW'(in_data.read_col));
            end
            rd_ok_nxt = rd_in_range;
            st_nxt    = ST_READ;
          end else if (in_data.char_code == txc_pkg::CODE_NEWLINE) begin
            col_nxt = '0;
            if (row_r == LAST_ROW) begin
              top_nxt    = (top_r == LAST_ROW) ? '0 : top_r + RW'(1);
              bl_row_nxt = top_r;
              bl_cnt_nxt = '0;
              bl_put_nxt = 1'b0;
              st_nxt     = ST_BLANK;
            end else begin
              row_nxt = row_r + RW'(1);
              fin     = 1'b1;
            end
          end else if (in_data.char_code == txc_pkg::CODE_BACKSPACE) begin
            if (col_r != '0) begin
              col_nxt = col_r - CW'(1);
            end
            fin = 1'b1;
          end else if (col_r == COLS_C) begin
            // Wrap pending: move to the next row before writing.
            if (row_r == LAST_ROW) begin
              top_nxt     = (top_r == LAST_ROW) ? '0 : top_r + RW'(1);
              bl_row_nxt  = top_r;
              bl_cnt_nxt  = '0;
              bl_put_nxt  = 1'b1;
              bl_char_nxt = in_data.char_code;
              st_nxt      = ST_BLANK;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = cell_addr(phys_row(row_r + RW'(1), top_r), '0);
              mem_wdata = {attr_r, in_data.char_code};
              row_nxt   = row_r + RW'(1);
              col_nxt   = CW'(1);
              fin       = 1'b1;
            end
          end else begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(phys_row(row_r, top_r), CIW'(col_r));
            mem_wdata = {attr_r, in_data.char_code};
            col_nxt   = col_r + CW'(1);
            fin       = 1'b1;
          end
          fin_res.cursor_col  = 7'(col_nxt);
          fin_res.cursor_line = 5'(row_nxt);
        end
      end

      ST_READ: begin
        fin                 = 1'b1;
        fin_res.cursor_col  = 7'(col_r);
        fin_res.cursor_line = 5'(row_r);
        if (rd_ok_r) begin
          fin_res.cell_char      = rdata_r[7:0];
          fin_res.cell_attribute = rdata_r[15:8];
        end
      end

      ST_BLANK: begin
        // Blank the new bottom row; a wrapped character lands in its first cell.
        mem_we    = 1'b1;
        mem_waddr = cell_addr(bl_row_r, bl_cnt_r);
        if (bl_put_r && (bl_cnt_r == '0)) begin
          mem_wdata = {attr_r, bl_char_r};
        end
        if (bl_cnt_r == LAST_COL) begin
          row_nxt             = LAST_ROW;
          col_nxt             = bl_put_r ? CW'(1) : '0;
          fin                 = 1'b1;
          fin_res.cursor_col  = 7'(col_nxt);
          fin_res.cursor_line = 5'(row_nxt);
          fin_res.scrolled    = 1'b1;
        end else begin
          bl_cnt_nxt = bl_cnt_r + CIW'(1);
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_data_nxt = res_r;
          st_nxt       = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // A finished result goes straight out when the output register is free.
    if (fin) begin
      if (out_free) begin
        out_data_nxt = fin_res;
        st_nxt       = ST_IDLE;
      end else begin
        res_nxt = fin_res;
        st_nxt  = ST_DONE;
      end
    end
  end

  assign out_valid_nxt = (fin & out_free) | ((st_r == ST_DONE) & out_free) |
                         (out_valid_r & ~out_ready);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      col_r       <= '0;
      row_r       <= '0;
      top_r       <= '0;
      attr_r      <= txc_pkg::RESET_ATTR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      top_r       <= top_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    bl_row_r   <= bl_row_nxt;
    bl_cnt_r   <= bl_cnt_nxt;
    bl_put_r   <= bl_put_nxt;
    bl_char_r  <= bl_char_nxt;
    rd_ok_r    <= rd_ok_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== hdl/txc_checker.sv =====
`include "assert_macros.svh"

module txc_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input txc_pkg::out_word_t out_data
);

  // Reset empties the result register and holds off input for the clearing pass.
  `ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!out_valid && !in_ready), "busy after reset")

  // A waiting result word holds until taken.
  `ASSERT_RUN(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "result word dropped or changed while stalled")

  // The cursor never leaves the screen (the wrap column included).
  `ASSERT_RUN(a_cursor_range, out_valid |-> ((32'(out_data.cursor_col) <= COLUMNS) && (32'(out_data.cursor_line) < ROWS)), "cursor off screen")

  // A scroll comes only from a put and leaves the cursor on the bottom row.
  `ASSERT_RUN(a_scroll_word, (out_valid && out_data.scrolled) |-> ((out_data.cell_char == 8'h00) && (out_data.cell_attribute == 8'h00) && (out_data.cursor_line == 5'(ROWS - 1))), "bad scroll word")

endmodule

bind text_console_writer txc_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_txc_checker (.*);
